FILE: hdl/brg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the binomial row generator.
package brg_pkg;

   localparam int DEGREE_W  = 6;
   localparam int INDEX_W   = 6;
   localparam int COEFF_W   = 57;
   localparam int FACTOR_W  = 6;
   localparam int PROD_W    = 63;
   localparam int DIVISOR_W = 6;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MUL,
      ST_DIV
   } brg_state_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
      logic [COEFF_W-1:0] value;
      logic               last;
      logic               too_large;
   } brg_push_type;

endpackage

FILE: hdl/brg_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the degree requests and the coefficient responses.
interface brg_req_if;
   import brg_pkg::*;

   logic                valid;
   logic                ready;
   logic [DEGREE_W-1:0] row_degree;

   modport source (output valid, output row_degree, input ready);
   modport sink (input valid, input row_degree, output ready);
endinterface

interface brg_rsp_if;
   import brg_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] coeff_index;
   logic [COEFF_W-1:0] coeff_value;
   logic               row_last;
   logic               too_large;

   modport source (output valid, output coeff_index, output coeff_value,
                   output row_last, output too_large, input ready);
   modport sink (input valid, input coeff_index, input coeff_value,
                 input row_last, input too_large, output ready);
endinterface

FILE: hdl/brg_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider producing one quotient bit per cycle.
module brg_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [brg_pkg::PROD_W-1:0]       dividend,
   input  logic [brg_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [brg_pkg::COEFF_W-1:0]      quotient
);
   import brg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    count_ff, count_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[PROD_W-2:0], fits};
         rem_in   = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
         count_in = count_ff + STEP_W'(1);
         if (count_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[COEFF_W-1:0];
endmodule

FILE: hdl/brg_ctrl.sv
`timescale 1ns / 1ps
// Row sequencer: walks k across the row, multiplies and drives the divider.
module brg_ctrl #(
   parameter int MAX_DEGREE = 60
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [brg_pkg::DEGREE_W-1:0]   req_degree,
   output logic                           req_ready,
   input  logic                           out_free,
   output brg_pkg::brg_push_type          push
);
   import brg_pkg::*;

   localparam logic [DEGREE_W-1:0] MaxDeg = DEGREE_W'(MAX_DEGREE);

   brg_state_type        state_ff, state_in;
   logic [DEGREE_W-1:0]  degree_ff, degree_in;
   logic [INDEX_W-1:0]   index_ff, index_in;
   logic [COEFF_W-1:0]   coeff_ff, coeff_in;
   logic                 big_ff, big_in;
   logic                 push_last;
   logic [FACTOR_W-1:0]  factor;
   logic [PROD_W-1:0]    product;
   logic                 div_start;
   logic                 div_done;
   logic [COEFF_W-1:0]   div_quotient;

   assign push_last = big_ff || (index_ff == degree_ff);
   assign factor    = FACTOR_W'(degree_ff - index_ff + DEGREE_W'(1));
   assign product   = {{(PROD_W-COEFF_W){1'b0}}, coeff_ff}
                      * {{(PROD_W-FACTOR_W){1'b0}}, factor};

   brg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (index_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = push_last ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      div_start      = 1'b0;
      degree_in      = degree_ff;
      index_in       = index_ff;
      coeff_in       = coeff_ff;
      big_in         = big_ff;
      push.valid     = 1'b0;
      push.index     = index_ff;
      push.value     = big_ff ? '0 : coeff_ff;
      push.last      = push_last;
      push.too_large = big_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               degree_in = req_degree;
               index_in  = '0;
               coeff_in  = COEFF_W'(1);
               big_in    = req_degree > MaxDeg;
            end
         end
         ST_EMIT: begin
            push.valid = out_free;
            if (out_free && !push_last) index_in = index_ff + INDEX_W'(1);
         end
         ST_MUL: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
            if (div_done) coeff_in = div_quotient;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      degree_ff <= degree_in;
      index_ff  <= index_in;
      coeff_ff  <= coeff_in;
      big_ff    <= big_in;
   end
endmodule

FILE: hdl/binomial_row_generator.sv
`timescale 1ns / 1ps
// Binomial row generator top level with the response output register.
// The first coefficient is pushed from the emit state into the response output register.
// Each further coefficient takes a multiply state, 63 divider steps and a handoff to emit.
// A row of degree n emits n + 1 coefficients; a refused degree emits a single response.
// Throughput: one degree at a time, bounded by the one-bit-per-cycle divider.
// Reset is synchronous and active high; it clears the sequencer and the response valid.
module binomial_row_generator #(
   parameter int MAX_DEGREE = 60
) (
   input  logic      clock,
   input  logic      reset,
   brg_req_if.sink   req_chan,
   brg_rsp_if.source rsp_chan
);
   import brg_pkg::*;

   brg_push_type       push;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [COEFF_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_big_ff, rsp_big_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   brg_ctrl #(
      .MAX_DEGREE (MAX_DEGREE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_degree (req_chan.row_degree),
      .req_ready  (req_chan.ready),
      .out_free   (out_free),
      .push       (push)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_big_in   = rsp_big_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = push.index;
         rsp_value_in = push.value;
         rsp_last_in  = push.last;
         rsp_big_in   = push.too_large;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_big_ff   <= rsp_big_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.coeff_index = rsp_index_ff;
   assign rsp_chan.coeff_value = rsp_value_ff;
   assign rsp_chan.row_last    = rsp_last_ff;
   assign rsp_chan.too_large   = rsp_big_ff;

`ifndef SYNTHESIS
   // A refused degree yields a single transaction with index and value cleared.
   a_refused_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.too_large |->
         rsp_chan.row_last && rsp_chan.coeff_index == '0 && rsp_chan.coeff_value == '0)
      else $error("refused row transaction malformed");

   // Every coefficient of an accepted row is non-zero, and the first one is unity.
   a_coeff_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.too_large |->
         rsp_chan.coeff_value != '0 &&
         (rsp_chan.coeff_index != '0 || rsp_chan.coeff_value == COEFF_W'(1)))
      else $error("bad coefficient value");

   // Once a degree is taken the block stops accepting until the row is finished.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while a row is in progress");
`endif
endmodule
